### rtl/cpu8x_pkg.sv
// cpu8x_pkg: shared types, operation codes and constants of the cpu8 execute unit
// no dependencies
`timescale 1ns / 1ps

package cpu8x_pkg;

	localparam int unsigned DATA_WORDS = 2048;
	localparam int unsigned DMEM_AW = $clog2(DATA_WORDS);
	localparam int unsigned PC_W = 11;

	localparam logic [7:0] CONTROL_RESET = 8'd28;

	// status bits
	localparam int unsigned SR_OVF = 0;
	localparam int unsigned SR_NZ = 2;
	localparam int unsigned SR_Z = 3;

	// control bits
	localparam int unsigned CR_BCZ = 0;
	localparam int unsigned CR_BCNZ = 1;
	localparam int unsigned CR_PAGE_LO = 2;
	localparam int unsigned CR_ADR = 5;

	// mapped register addresses
	localparam logic [PC_W-1:0] ADDR_CONTROL = 11'd4;
	localparam logic [PC_W-1:0] ADDR_STATUS = 11'd5;
	localparam logic [PC_W-1:0] ADDR_STACK = 11'd6;
	localparam logic [PC_W-1:0] ADDR_RESERVED = 11'd7;

	localparam logic [1:0] ERR_NONE = 2'd0;
	localparam logic [1:0] ERR_RESERVED = 2'd1;
	localparam logic [1:0] ERR_STATUS_WR = 2'd2;

	typedef enum logic [3:0] {
		FN_NOP = 4'd0,
		FN_ADD = 4'd1,
		FN_SUB = 4'd2,
		FN_AND = 4'd3,
		FN_OR = 4'd4,
		FN_XOR = 4'd5,
		FN_LOAD = 4'd6,
		FN_STORE = 4'd7,
		FN_JUMP = 4'd8,
		FN_CALL = 4'd9,
		FN_RET = 4'd10,
		FN_SET_BZ = 4'd11,
		FN_SET_BNZ = 4'd12,
		FN_CLR_BR = 4'd13,
		FN_SET_ADR = 4'd14,
		FN_CLR_ADR = 4'd15
	} func_t;

	typedef struct packed {
		logic [3:0] func;
		logic [1:0] src_reg_a;
		logic [1:0] src_reg_b;
		logic [1:0] dest_reg;
		logic use_immediate;
		logic [7:0] immediate;
		logic [PC_W-1:0] address;
		logic [PC_W-1:0] return_pc;
	} op_item_t;

	typedef struct packed {
		logic redirect;
		logic [PC_W-1:0] target_pc;
		logic [1:0] error_code;
		logic [7:0] write_value;
		logic [3:0] status_flags;
	} res_item_t;

	// state update produced by the execute logic at the end of an operation
	typedef struct packed {
		logic reg_we;
		logic [1:0] reg_idx;
		logic [7:0] reg_val;
		logic [7:0] status_next;
		logic [7:0] control_next;
		logic [7:0] sp_next;
		logic mem_we;
		logic [DMEM_AW-1:0] mem_addr;
		logic [7:0] mem_wdata;
	} upd_t;

	// memory accesses issued in the first phase of an operation
	typedef struct packed {
		logic [DMEM_AW-1:0] rd_addr_a;
		logic [DMEM_AW-1:0] rd_addr_b;
		logic push_we;
		logic [DMEM_AW-1:0] push_addr;
		logic [7:0] push_data;
	} issue_t;

endpackage

### rtl/cpu8x_dmem.sv
// cpu8x_dmem: byte data memory, one write port and two registered read ports
// depends on cpu8x_pkg
`timescale 1ns / 1ps

module cpu8x_dmem import cpu8x_pkg::*; (
	input  logic clk,
	input  logic we,
	input  logic [DMEM_AW-1:0] waddr,
	input  logic [7:0] wdata,
	input  logic re,
	input  logic [DMEM_AW-1:0] raddr_a,
	input  logic [DMEM_AW-1:0] raddr_b,
	output logic [7:0] rdata_a,
	output logic [7:0] rdata_b
);

	logic [7:0] mem [DATA_WORDS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

### rtl/cpu8x_exec.sv
// cpu8x_exec: operand select, alu, address generation and next-state logic
// depends on cpu8x_pkg
`timescale 1ns / 1ps

module cpu8x_exec import cpu8x_pkg::*; (
	input  op_item_t op,
	input  logic [7:0] regs [4],
	input  logic [7:0] status,
	input  logic [7:0] control,
	input  logic [7:0] sp,
	input  logic [7:0] mem_a,
	input  logic [7:0] mem_b,
	output issue_t iss,
	output upd_t upd,
	output res_item_t res
);

	logic [7:0] a;
	logic [7:0] b;
	logic [8:0] sum9;
	logic [8:0] diff9;
	logic [7:0] alu8;
	logic ovf;
	logic [DMEM_AW-1:0] daddr;
	logic [DMEM_AW-1:0] sbase;
	logic [7:0] index_add;
	logic [7:0] load_val;
	logic take;
	logic bz;
	logic bnz;

	assign a = regs[op.src_reg_a];
	assign b = op.use_immediate ? op.immediate : regs[op.src_reg_b];
	assign sum9 = {1'b0, a} + {1'b0, b};
	assign diff9 = {1'b0, a} - {1'b0, b};

	assign index_add = control[CR_ADR] ? regs[3] : 8'd0;
	assign daddr = DMEM_AW'({1'b0, op.address} + {4'd0, index_add});
	assign sbase = DMEM_AW'({control[CR_PAGE_LO +: 3], sp});

	assign bz = control[CR_BCZ];
	assign bnz = control[CR_BCNZ];

	always_comb begin
		if (bz && bnz) begin
			take = status[SR_OVF];
		end else if (bz) begin
			take = status[SR_Z];
		end else if (bnz) begin
			take = status[SR_NZ];
		end else begin
			take = 1'b1;
		end
	end

	always_comb begin
		if (op.address < ADDR_CONTROL) begin
			load_val = regs[op.address[1:0]];
		end else if (op.address == ADDR_CONTROL) begin
			load_val = control;
		end else if (op.address == ADDR_STATUS) begin
			load_val = status;
		end else if (op.address == ADDR_STACK) begin
			load_val = sp;
		end else begin
			load_val = mem_a;
		end
	end

	// first phase: reads for load and return, high byte push for call
	always_comb begin
		iss.rd_addr_a = (func_t'(op.func) == FN_RET) ? sbase - DMEM_AW'(2) : daddr;
		iss.rd_addr_b = sbase - DMEM_AW'(1);
		iss.push_we = (func_t'(op.func) == FN_CALL);
		iss.push_addr = sbase;
		iss.push_data = {5'd0, op.return_pc[10:8]};
	end

	always_comb begin
		upd.reg_we = 1'b0;
		upd.reg_idx = op.dest_reg;
		upd.reg_val = 8'd0;
		upd.status_next = status;
		upd.control_next = control;
		upd.sp_next = sp;
		upd.mem_we = 1'b0;
		upd.mem_addr = daddr;
		upd.mem_wdata = regs[op.dest_reg];
		res.redirect = 1'b0;
		res.target_pc = '0;
		res.error_code = ERR_NONE;
		res.write_value = 8'd0;
		alu8 = 8'd0;
		ovf = 1'b0;

		case (func_t'(op.func))
			FN_ADD, FN_SUB: begin
				alu8 = (func_t'(op.func) == FN_ADD) ? sum9[7:0] : diff9[7:0];
				ovf = (func_t'(op.func) == FN_ADD) ? sum9[8] : diff9[8];
				upd.reg_we = 1'b1;
				upd.reg_val = alu8;
				res.write_value = alu8;
				upd.status_next[SR_OVF] = ovf;
				upd.status_next[SR_NZ] = (alu8 != 8'd0);
				upd.status_next[SR_Z] = (alu8 == 8'd0);
			end
			FN_AND, FN_OR, FN_XOR: begin
				case (func_t'(op.func))
					FN_AND: alu8 = a & b;
					FN_OR: alu8 = a | b;
					default: alu8 = a ^ b;
				endcase
				upd.reg_we = 1'b1;
				upd.reg_val = alu8;
				res.write_value = alu8;
				upd.status_next[SR_OVF] = 1'b0;
			end
			FN_LOAD: begin
				if (op.address == ADDR_RESERVED) begin
					res.error_code = ERR_RESERVED;
				end else begin
					upd.reg_we = 1'b1;
					upd.reg_val = load_val;
					res.write_value = load_val;
				end
			end
			FN_STORE: begin
				if (op.address == ADDR_RESERVED) begin
					res.error_code = ERR_RESERVED;
				end else if (op.address == ADDR_STATUS) begin
					res.error_code = ERR_STATUS_WR;
				end else begin
					res.write_value = regs[op.dest_reg];
					if (op.address < ADDR_CONTROL) begin
						upd.reg_we = 1'b1;
						upd.reg_idx = op.address[1:0];
						upd.reg_val = regs[op.dest_reg];
					end else if (op.address == ADDR_CONTROL) begin
						upd.control_next = regs[op.dest_reg];
					end else if (op.address == ADDR_STACK) begin
						upd.sp_next = regs[op.dest_reg];
					end else begin
						upd.mem_we = 1'b1;
					end
				end
			end
			FN_JUMP: begin
				res.redirect = take;
				res.target_pc = take ? op.address : '0;
				upd.status_next[SR_OVF] = 1'b0;
				upd.status_next[SR_NZ] = 1'b0;
				upd.status_next[SR_Z] = 1'b0;
			end
			FN_CALL: begin
				// low byte goes on the stack in the second phase, at commit
				upd.mem_we = 1'b1;
				upd.mem_addr = sbase + DMEM_AW'(1);
				upd.mem_wdata = op.return_pc[7:0];
				res.write_value = op.return_pc[7:0];
				upd.sp_next = sp + 8'd2;
				res.redirect = 1'b1;
				res.target_pc = op.address;
			end
			FN_RET: begin
				upd.sp_next = sp - 8'd2;
				res.redirect = 1'b1;
				res.target_pc = {mem_a[2:0], mem_b};
			end
			FN_SET_BZ: begin
				upd.control_next[CR_BCZ] = 1'b1;
				res.write_value = upd.control_next;
			end
			FN_SET_BNZ: begin
				upd.control_next[CR_BCNZ] = 1'b1;
				res.write_value = upd.control_next;
			end
			FN_CLR_BR: begin
				upd.control_next[CR_BCZ] = 1'b0;
				upd.control_next[CR_BCNZ] = 1'b0;
				res.write_value = upd.control_next;
			end
			FN_SET_ADR: begin
				upd.control_next[CR_ADR] = 1'b1;
				res.write_value = upd.control_next;
			end
			FN_CLR_ADR: begin
				upd.control_next[CR_ADR] = 1'b0;
				res.write_value = upd.control_next;
			end
			default: begin
			end
		endcase

		res.status_flags = upd.status_next[3:0];
	end

endmodule

### rtl/cpu8_execute_unit_core.sv
// cpu8_execute_unit_core: top level of the cpu8 execute unit
// depends on cpu8x_pkg, cpu8x_dmem, cpu8x_exec
`timescale 1ns / 1ps

// Usage
// The op channel (op_valid/op_ready/op) takes one pre-decoded operation per
// transaction; the res channel (res_valid/res_ready/res) returns exactly one
// result per operation, in order.
// Each operation is held in the execute register through a first and a second phase: in the first the
// data memory is read (load, return) or the high return byte is pushed (call);
// in the second the result is formed, registers, status, control, stack pointer
// and memory are updated, and the result moves into the output register.
// The split into phases is set by the single write port of the data memory
// (call pushes two bytes) and the registered reads of load and return.
// A new operation is accepted in the cycle the current one finishes, while the
// previous result may still sit in the output register.
// If the receiver stalls, the finished operation waits in its second phase
// until the output register frees, and op_ready stays low meanwhile.
// Reset clears status and stack pointer, loads the control register with its
// reset value and empties the pipeline; register file and data memory contents
// are undefined until written.

module cpu8_execute_unit_core import cpu8x_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic op_valid,
	output logic op_ready,
	input  op_item_t op,
	output logic res_valid,
	input  logic res_ready,
	output res_item_t res
);

	op_item_t op_s1;
	logic valid_s1;
	logic phase_q;

	logic [7:0] regs_q [4];
	logic [7:0] status_q;
	logic [7:0] control_q;
	logic [7:0] sp_q;

	res_item_t res_q;
	logic res_valid_q;

	logic [7:0] mem_a;
	logic [7:0] mem_b;
	issue_t iss;
	upd_t upd;
	res_item_t res_next;

	logic out_free;
	logic commit;
	logic issue;
	logic mem_we;
	logic [DMEM_AW-1:0] mem_waddr;
	logic [7:0] mem_wdata;

	assign out_free = !res_valid_q || res_ready;
	assign issue = valid_s1 && !phase_q;
	assign commit = valid_s1 && phase_q && out_free;
	assign op_ready = !valid_s1 || commit;

	cpu8x_exec u_exec (
		.op(op_s1),
		.regs(regs_q),
		.status(status_q),
		.control(control_q),
		.sp(sp_q),
		.mem_a(mem_a),
		.mem_b(mem_b),
		.iss(iss),
		.upd(upd),
		.res(res_next)
	);

	// one write port: push of the call high byte in the first phase,
	// store or call low byte at commit
	always_comb begin
		if (issue) begin
			mem_we = iss.push_we;
			mem_waddr = iss.push_addr;
			mem_wdata = iss.push_data;
		end else begin
			mem_we = commit && upd.mem_we;
			mem_waddr = upd.mem_addr;
			mem_wdata = upd.mem_wdata;
		end
	end

	cpu8x_dmem u_dmem (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re(issue),
		.raddr_a(iss.rd_addr_a),
		.raddr_b(iss.rd_addr_b),
		.rdata_a(mem_a),
		.rdata_b(mem_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			phase_q <= 1'b0;
		end else begin
			if (op_valid && op_ready) begin
				valid_s1 <= 1'b1;
				phase_q <= 1'b0;
			end else if (commit) begin
				valid_s1 <= 1'b0;
				phase_q <= 1'b0;
			end else if (issue) begin
				phase_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (op_valid && op_ready) begin
			op_s1 <= op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q <= 8'd0;
			control_q <= CONTROL_RESET;
			sp_q <= 8'd0;
		end else if (commit) begin
			status_q <= upd.status_next;
			control_q <= upd.control_next;
			sp_q <= upd.sp_next;
		end
	end

	always_ff @(posedge clk) begin
		if (commit && upd.reg_we) begin
			regs_q[upd.reg_idx] <= upd.reg_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (commit) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			res_q <= res_next;
		end
	end

	assign res_valid = res_valid_q;
	assign res = res_q;

endmodule
